// ===== hdl/hlbc_pkg.sv =====
package hlbc_pkg;

  localparam int NUM_BUFFERS_DEF = 32;
  localparam int NUM_BUCKETS_DEF = 13;
  localparam logic [7:0] COUNT_MAX = 8'd255;

  localparam logic [1:0] KIND_GET     = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_PIN     = 2'd2;
  localparam logic [1:0] KIND_UNPIN   = 2'd3;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NO_FREE   = 2'd1;
  localparam logic [1:0] STAT_UNDERFLOW = 2'd2;
  localparam logic [1:0] STAT_OVERFLOW  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OP,
    ST_MOD,
    ST_HIT,
    ST_MISS,
    ST_UNLINK,
    ST_PUSH
  } hlbc_state_t;

endpackage

// ===== hdl/hashed_lru_buffer_cache_tags.sv =====
// Buffer cache tag and replacement manager.
// Input channel (in_*): one transaction per request. kind selects get, release,
// pin or unpin; get uses device_id and block_number, the others buffer_index.
// Result channel (out_*): exactly one transaction per request, in order,
// carrying slot, hit, needs_fill and status.
// The result of a release, pin or unpin is registered in the cycle after the
// request is taken (after ST_UNLINK and ST_PUSH when a release moves the
// buffer). A get computes the bucket number (block number modulo bucket count)
// through one shared multiplier: fold the upper half, take a reciprocal
// quotient, subtract. It then walks the home bucket one link per cycle, on a
// miss walks the buckets from their tails one link per cycle, and relinks a
// buffer taken from another bucket in ST_UNLINK and ST_PUSH.
// The block takes one request at a time; in_stall is high while it works.
// The next request is taken once the block is back in ST_IDLE and the
// output register is empty or being drained.
// When the receiver stalls, the result holds and no new request is taken.
// Reset clears tags, counts and valid bits and chains every buffer into
// bucket zero, buffer 0 least recent.
module hashed_lru_buffer_cache_tags #(
  parameter int NUM_BUFFERS = hlbc_pkg::NUM_BUFFERS_DEF,
  parameter int NUM_BUCKETS = hlbc_pkg::NUM_BUCKETS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_device_id,
  input  logic [31:0] in_block_number,
  input  logic [4:0]  in_buffer_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_slot,
  output logic        out_hit,
  output logic        out_needs_fill,
  output logic [1:0]  out_status
);
  import hlbc_pkg::*;

  localparam int NODE_CNT = NUM_BUFFERS + NUM_BUCKETS;
  localparam int NODE_W   = $clog2(NODE_CNT);
  localparam int SLOT_W   = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam int BKT_W    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int GRD_W    = $clog2(NUM_BUFFERS + 1);
  // 2^16 modulo the bucket count folds the upper half onto the lower half
  localparam int FOLD_MUL = (1 << 16) % NUM_BUCKETS;
  localparam int RECIP_SH = 26;
  localparam logic [26:0] RECIP =
    27'(((64'd1 << RECIP_SH) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS));

  // tag store and per-buffer bookkeeping
  logic [31:0]       tag_dev_r  [NUM_BUFFERS];
  logic [31:0]       tag_blk_r  [NUM_BUFFERS];
  logic [7:0]        cnt_r      [NUM_BUFFERS];
  logic              vld_r      [NUM_BUFFERS];
  logic [BKT_W-1:0]  tbkt_r     [NUM_BUFFERS];
  // recency rings: nodes below NUM_BUFFERS are buffers, the rest bucket heads
  logic [NODE_W-1:0] buf_nxt_r  [NUM_BUFFERS];
  logic [NODE_W-1:0] buf_prv_r  [NUM_BUFFERS];
  logic [NODE_W-1:0] head_nxt_r [NUM_BUCKETS];
  logic [NODE_W-1:0] head_prv_r [NUM_BUCKETS];

  hlbc_state_t state_r, state_nxt;

  logic [1:0]        kind_r;
  logic [31:0]       dev_r;
  logic [31:0]       blk_r;
  logic [4:0]        idx_r;
  logic [1:0]        mod_step_r;
  logic [20:0]       fold_r;
  logic [20:0]       quo_r;
  logic [BKT_W-1:0]  home_r;
  logic [BKT_W-1:0]  bkt_r;
  logic [BKT_W-1:0]  k_r;
  logic [NODE_W-1:0] n_r;
  logic [GRD_W-1:0]  guard_r;
  logic [NODE_W-1:0] push_node_r;
  logic [BKT_W-1:0]  push_bkt_r;

  logic              out_valid_r;
  logic [4:0]        out_slot_r;
  logic              out_hit_r;
  logic              out_fill_r;
  logic [1:0]        out_status_r;

  logic              in_take;
  logic [20:0]       mul_a;
  logic [26:0]       mul_b;
  logic [47:0]       mul_p;
  logic [20:0]       fold_new;
  logic [20:0]       quo_new;
  logic [20:0]       rem_full;
  logic [BKT_W-1:0]  rem_new;
  logic [BKT_W-1:0]  bkt_step;
  logic [NODE_W-1:0] home_head;
  logic [NODE_W-1:0] cur_head;
  logic [SLOT_W-1:0] ns;
  logic [SLOT_W-1:0] is;
  logic [BKT_W-1:0]  n_bkt;
  logic [NODE_W-1:0] nxt_of_n;
  logic [NODE_W-1:0] prv_of_n;
  logic [SLOT_W-1:0] ps;
  logic [NODE_W-1:0] pn_nxt;
  logic [NODE_W-1:0] pn_prv;
  logic              pnn_buf;
  logic              pnp_buf;
  logic [SLOT_W-1:0] pnn_slot;
  logic [SLOT_W-1:0] pnp_slot;
  logic [BKT_W-1:0]  pnn_bkt;
  logic [BKT_W-1:0]  pnp_bkt;
  logic [NODE_W-1:0] push_head;
  logic [NODE_W-1:0] push_first;
  logic              pf_buf;
  logic [SLOT_W-1:0] pf_slot;
  logic [BKT_W-1:0]  pf_bkt;
  logic              n_is_buf;
  logic              idx_ok;
  logic              walk_end;
  logic              tag_match;
  logic              can_take;
  logic              last_bkt;

  assign in_stall       = !(state_r == ST_IDLE && (!out_valid_r || !out_stall));
  assign in_take        = in_valid && !in_stall;
  assign out_valid      = out_valid_r;
  assign out_slot       = out_slot_r;
  assign out_hit        = out_hit_r;
  assign out_needs_fill = out_fill_r;
  assign out_status     = out_status_r;

  // shared multiplier for the bucket number: fold, reciprocal quotient, product
  always_comb begin
    case (mod_step_r)
      2'd2: begin
        mul_a = 21'(blk_r[31:16]);
        mul_b = 27'(FOLD_MUL);
      end
      2'd1: begin
        mul_a = fold_r;
        mul_b = RECIP;
      end
      default: begin
        mul_a = quo_r;
        mul_b = 27'(NUM_BUCKETS);
      end
    endcase
    mul_p    = 48'(mul_a) * 48'(mul_b);
    fold_new = 21'(mul_p) + 21'(blk_r[15:0]);
    quo_new  = 21'(mul_p >> RECIP_SH);
    rem_full = fold_r - 21'(mul_p);
    rem_new  = BKT_W'(rem_full);
  end

  always_comb begin
    bkt_step  = (bkt_r == BKT_W'(NUM_BUCKETS - 1)) ? '0 : bkt_r + 1'b1;
    home_head = NODE_W'(NUM_BUFFERS) + NODE_W'(home_r);
    cur_head  = NODE_W'(NUM_BUFFERS) + NODE_W'(bkt_r);
    ns        = SLOT_W'(n_r);
    is        = SLOT_W'(idx_r);
    n_is_buf  = (32'(n_r) < 32'(NUM_BUFFERS));
    idx_ok    = (32'(idx_r) < 32'(NUM_BUFFERS));
    n_bkt     = BKT_W'(n_r - NODE_W'(NUM_BUFFERS));
    nxt_of_n  = n_is_buf ? buf_nxt_r[ns] : head_nxt_r[n_bkt];
    prv_of_n  = n_is_buf ? buf_prv_r[ns] : head_prv_r[n_bkt];
    ps        = SLOT_W'(push_node_r);
    pn_nxt    = buf_nxt_r[ps];
    pn_prv    = buf_prv_r[ps];
    pnn_buf   = (32'(pn_nxt) < 32'(NUM_BUFFERS));
    pnp_buf   = (32'(pn_prv) < 32'(NUM_BUFFERS));
    pnn_slot  = SLOT_W'(pn_nxt);
    pnp_slot  = SLOT_W'(pn_prv);
    pnn_bkt   = BKT_W'(pn_nxt - NODE_W'(NUM_BUFFERS));
    pnp_bkt   = BKT_W'(pn_prv - NODE_W'(NUM_BUFFERS));
    push_head = NODE_W'(NUM_BUFFERS) + NODE_W'(push_bkt_r);
    push_first = head_nxt_r[push_bkt_r];
    pf_buf    = (32'(push_first) < 32'(NUM_BUFFERS));
    pf_slot   = SLOT_W'(push_first);
    pf_bkt    = BKT_W'(push_first - NODE_W'(NUM_BUFFERS));
    walk_end  = (guard_r == GRD_W'(NUM_BUFFERS)) ||
                (state_r == ST_HIT ? (n_r == home_head) : (n_r == cur_head));
    tag_match = n_is_buf && tag_dev_r[ns] == dev_r && tag_blk_r[ns] == blk_r;
    can_take  = n_is_buf && cnt_r[ns] == 8'd0;
    last_bkt  = (k_r == BKT_W'(NUM_BUCKETS - 1));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          state_nxt = (in_kind == KIND_GET) ? ST_MOD : ST_OP;
        end
      end
      ST_OP: begin
        if (kind_r == KIND_RELEASE && idx_ok && cnt_r[is] == 8'd1) begin
          state_nxt = ST_UNLINK;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_MOD: begin
        if (mod_step_r == 2'd0) begin
          state_nxt = ST_HIT;
        end
      end
      ST_HIT: begin
        if (walk_end) begin
          state_nxt = ST_MISS;
        end else if (tag_match) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_MISS: begin
        if (walk_end) begin
          if (last_bkt) begin
            state_nxt = ST_IDLE;
          end
        end else if (can_take) begin
          state_nxt = (bkt_r != home_r) ? ST_UNLINK : ST_IDLE;
        end
      end
      ST_UNLINK: state_nxt = ST_PUSH;
      ST_PUSH:   state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath and table updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        tag_dev_r[i] <= '0;
        tag_blk_r[i] <= '0;
        cnt_r[i]     <= '0;
        vld_r[i]     <= 1'b0;
        tbkt_r[i]    <= '0;
        buf_nxt_r[i] <= (i == 0) ? NODE_W'(NUM_BUFFERS) : NODE_W'(i - 1);
        buf_prv_r[i] <= (i == NUM_BUFFERS - 1) ? NODE_W'(NUM_BUFFERS) : NODE_W'(i + 1);
      end
      // bucket zero holds every buffer: most recent is the highest index
      for (int b = 0; b < NUM_BUCKETS; b++) begin
        head_nxt_r[b] <= (b == 0) ? NODE_W'(NUM_BUFFERS - 1) : NODE_W'(NUM_BUFFERS + b);
        head_prv_r[b] <= (b == 0) ? '0 : NODE_W'(NUM_BUFFERS + b);
      end
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_take) begin
            kind_r     <= in_kind;
            dev_r      <= in_device_id;
            blk_r      <= in_block_number;
            idx_r      <= in_buffer_index;
            mod_step_r <= 2'd2;
          end
        end
        ST_OP: begin
          out_slot_r   <= idx_r;
          out_hit_r    <= 1'b0;
          out_fill_r   <= 1'b0;
          out_status_r <= STAT_OK;
          push_node_r  <= NODE_W'(idx_r);
          push_bkt_r   <= tbkt_r[is];
          if (idx_ok) begin
            if (kind_r == KIND_PIN) begin
              if (cnt_r[is] == COUNT_MAX) begin
                out_status_r <= STAT_OVERFLOW;
              end else begin
                cnt_r[is] <= cnt_r[is] + 8'd1;
              end
            end else if (cnt_r[is] == 8'd0) begin
              out_status_r <= STAT_UNDERFLOW;
            end else begin
              cnt_r[is] <= cnt_r[is] - 8'd1;
            end
          end
          // a release reaching zero finishes after the relink
          if (!(kind_r == KIND_RELEASE && idx_ok && cnt_r[is] == 8'd1)) begin
            out_valid_r <= 1'b1;
          end
        end
        ST_MOD: begin
          mod_step_r <= mod_step_r - 2'd1;
          case (mod_step_r)
            2'd2: fold_r <= fold_new;
            2'd1: quo_r  <= quo_new;
            default: begin
              home_r  <= rem_new;
              bkt_r   <= rem_new;
              k_r     <= '0;
              n_r     <= head_nxt_r[rem_new];
              guard_r <= '0;
            end
          endcase
        end
        ST_HIT: begin
          if (walk_end) begin
            // start the victim search at the tail of the home bucket
            n_r     <= head_prv_r[home_r];
            guard_r <= '0;
          end else if (tag_match) begin
            out_slot_r   <= 5'(n_r);
            out_hit_r    <= 1'b1;
            out_fill_r   <= !vld_r[ns];
            out_status_r <= (cnt_r[ns] == COUNT_MAX) ? STAT_OVERFLOW : STAT_OK;
            if (cnt_r[ns] != COUNT_MAX) begin
              cnt_r[ns] <= cnt_r[ns] + 8'd1;
            end
            vld_r[ns]   <= 1'b1;
            out_valid_r <= 1'b1;
          end else begin
            n_r     <= nxt_of_n;
            guard_r <= guard_r + 1'b1;
          end
        end
        ST_MISS: begin
          if (walk_end) begin
            if (last_bkt) begin
              out_slot_r   <= '0;
              out_hit_r    <= 1'b0;
              out_fill_r   <= 1'b0;
              out_status_r <= STAT_NO_FREE;
              out_valid_r  <= 1'b1;
            end else begin
              k_r     <= k_r + 1'b1;
              bkt_r   <= bkt_step;
              n_r     <= head_prv_r[bkt_step];
              guard_r <= '0;
            end
          end else if (can_take) begin
            tag_dev_r[ns] <= dev_r;
            tag_blk_r[ns] <= blk_r;
            tbkt_r[ns]    <= home_r;
            cnt_r[ns]     <= 8'd1;
            vld_r[ns]     <= 1'b1;
            out_slot_r    <= 5'(n_r);
            out_hit_r     <= 1'b0;
            out_fill_r    <= 1'b1;
            out_status_r  <= STAT_OK;
            push_node_r   <= n_r;
            push_bkt_r    <= home_r;
            if (bkt_r == home_r) begin
              out_valid_r <= 1'b1;
            end
          end else begin
            n_r     <= prv_of_n;
            guard_r <= guard_r + 1'b1;
          end
        end
        ST_UNLINK: begin
          if (pnn_buf) begin
            buf_prv_r[pnn_slot] <= pn_prv;
          end else begin
            head_prv_r[pnn_bkt] <= pn_prv;
          end
          if (pnp_buf) begin
            buf_nxt_r[pnp_slot] <= pn_nxt;
          end else begin
            head_nxt_r[pnp_bkt] <= pn_nxt;
          end
        end
        ST_PUSH: begin
          buf_nxt_r[ps] <= push_first;
          buf_prv_r[ps] <= push_head;
          if (pf_buf) begin
            buf_prv_r[pf_slot] <= push_node_r;
          end else begin
            head_prv_r[pf_bkt] <= push_node_r;
          end
          head_nxt_r[push_bkt_r] <= push_node_r;
          out_valid_r <= 1'b1;
        end
        default: begin
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

endmodule
